/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the release tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define DRT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

/* rtl/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Types and constants shared by the display buffer release tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int unsigned MAX_SLOTS = 4;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned PCNT_W    = 4;

  typedef enum logic [1:0] {
    MODE_PRESENT = 2'd0,
    MODE_SCANOUT = 2'd1,
    MODE_POOLRST = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PCNT_W-1:0] pending_count;
    logic              present_dropped;
    logic [SLOT_W-1:0] release_slot;
    logic              release_valid;
    logic              last;
  } beat_t;

endpackage

/* rtl/display_buffer_release_tracker.sv */
// ----------------------------------------------------------------------------
// display_buffer_release_tracker
// Tracks buffer slots queued for scanout and hands back displayed slots.
// ----------------------------------------------------------------------------
// After acceptance an event passes an ST_RD and an ST_POP state for each
// entry popped from the pending ring (a scanout pops at most one, a present
// drains to one below the drain limit), then ST_DONE, where its last result
// beat is loaded into the output register. Each pop needs both states since
// the ring is a synchronous memory with registered read data: the read is
// issued in ST_RD, the release decision and head advance follow in ST_POP.
// One event is in flight at a time; the sequencer can take the next event in
// the cycle after the final beat is loaded. The output register lets the next
// event be accepted while the final beat of the previous one waits for the
// sink; any beat that finds the register still full stalls the sequencer
// until the sink takes it. An event gives one beat per released slot, or a
// single empty beat, and tlast marks its final beat.
`include "assert_macros.svh"

module display_buffer_release_tracker
  import drt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,     // slot_count
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [2:0] slot, [7:3] zero
  input  logic [1:0] s_axis_tuser,    // [1:0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [0] release_valid, [2:1] release_slot,
                                      // [3] present_dropped, [7:4] pending_count
  output logic       m_axis_tlast     // last
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [2:0]        slot_count_q, slot_count_d;
  logic              out_valid_q, out_valid_d;
  beat_t             out_beat_q, out_beat_d;

  logic              emit_valid;
  logic              emit_ready;
  beat_t             emit_beat;
  logic [CW-1:0]     ring_count;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [SLOT_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [SLOT_W-1:0] mem_wr_data;

  // Saturate the slot count into 1..MAX_SLOTS.
  always_comb begin
    slot_count_d = slot_count_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == 3'd0) begin
        slot_count_d = 3'd1;
      end else if (4'(cfg_wdata_i) > 4'(MAX_SLOTS)) begin
        slot_count_d = 3'(MAX_SLOTS);
      end else begin
        slot_count_d = cfg_wdata_i;
      end
    end
  end

  assign emit_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;
    if (emit_valid && emit_ready) begin
      out_valid_d = 1'b1;
      out_beat_d  = emit_beat;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= 3'd3;
      out_valid_q  <= 1'b0;
    end else begin
      slot_count_q <= slot_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
  end

  drt_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_mode_i     (s_axis_tuser),
    .in_slot_i     (s_axis_tdata[2:0]),
    .slot_count_i  (slot_count_q),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .emit_valid_o  (emit_valid),
    .emit_beat_o   (emit_beat),
    .emit_ready_i  (emit_ready),
    .ring_count_o  (ring_count)
  );

  drt_ring #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_beat_q.pending_count, out_beat_q.present_dropped,
                          out_beat_q.release_slot, out_beat_q.release_valid};
  assign m_axis_tlast  = out_beat_q.last;

  `DRT_ASSERT(a_count_bound, clk_i, rst_ni, ring_count <= CW'(QUEUE_DEPTH - 1), "ring over limit")
  `DRT_ASSERT(a_one_event, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second event taken while busy")
  `DRT_ASSERT(a_last_frees, clk_i, rst_ni, (emit_valid && emit_ready && emit_beat.last) |=> s_axis_tready, "sequencer not idle after final beat")
  `DRT_ASSERT_NEVER(a_slot_count_zero, clk_i, rst_ni, slot_count_q == 3'd0, "slot count is zero")

endmodule

/* rtl/drt_ring.sv */
// ----------------------------------------------------------------------------
// drt_ring
// Pending slot ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module drt_ring
  import drt_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [SLOT_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [SLOT_W-1:0] rd_data_o
);

  logic [SLOT_W-1:0] mem_q [DEPTH];
  logic [SLOT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read enable.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/drt_ctrl.sv */
// ----------------------------------------------------------------------------
// drt_ctrl
// Event sequencer: drains, pops and appends the pending ring and builds the
// result beats, one pending release held back to learn which one is last.
// ----------------------------------------------------------------------------
module drt_ctrl
  import drt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned AW          = 3,
  parameter int unsigned CW          = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_mode_i,
  input  logic [2:0]        in_slot_i,
  input  logic [2:0]        slot_count_i,
  output logic              mem_rd_en_o,
  output logic [AW-1:0]     mem_rd_addr_o,
  input  logic [SLOT_W-1:0] mem_rd_data_i,
  output logic              mem_wr_en_o,
  output logic [AW-1:0]     mem_wr_addr_o,
  output logic [SLOT_W-1:0] mem_wr_data_o,
  output logic              emit_valid_o,
  output beat_t             emit_beat_o,
  input  logic              emit_ready_i,
  output logic [CW-1:0]     ring_count_o
);

  localparam int unsigned SW = CW + 1;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     head_q, head_d;
  logic              lat_valid_q, lat_valid_d;
  logic [SLOT_W-1:0] lat_slot_q, lat_slot_d;
  logic              held_valid_q, held_valid_d;
  logic [SLOT_W-1:0] held_slot_q, held_slot_d;
  logic [CW-1:0]     tgt_q, tgt_d;
  logic [CW-1:0]     fin_q, fin_d;
  logic              dropped_q, dropped_d;
  logic              append_q, append_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [CW-1:0]     thr;
  logic [CW-1:0]     lim;
  logic [CW-1:0]     drain_tgt;
  logic              accept;
  logic              rel;
  logic              pop_go;
  logic              done_go;
  logic [AW-1:0]     head_inc;
  logic [SW-1:0]     tail_sum;
  logic [AW-1:0]     tail_addr;
  logic [CW-1:0]     count_dec;

  // Drain limit: the lower of the slot threshold and one short of full.
  assign thr       = (slot_count_i > 3'd2) ? (CW'(slot_count_i) - CW'(1)) : CW'(2);
  assign lim       = (thr < CW'(QUEUE_DEPTH - 1)) ? thr : CW'(QUEUE_DEPTH - 1);
  assign drain_tgt = (count_q >= lim) ? (lim - CW'(1)) : count_q;

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign rel       = lat_valid_q && (lat_slot_q != mem_rd_data_i);
  assign pop_go    = !(rel && held_valid_q) || emit_ready_i;
  assign done_go   = emit_ready_i;
  assign count_dec = count_q - CW'(1);

  assign head_inc  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : (head_q + AW'(1));
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : AW'(tail_sum);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(in_mode_i))
            MODE_PRESENT: begin
              if ((in_slot_i < slot_count_i) && (count_q > drain_tgt)) begin
                state_d = ST_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            MODE_SCANOUT: begin
              state_d = (count_q != '0) ? ST_RD : ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RD: state_d = ST_POP;
      ST_POP: begin
        if (pop_go) begin
          state_d = (count_dec > tgt_q) ? ST_RD : ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    mem_rd_en_o   = (state_q == ST_RD);
    mem_rd_addr_o = head_q;
    mem_wr_en_o   = (state_q == ST_DONE) && done_go && append_q;
    mem_wr_addr_o = tail_addr;
    mem_wr_data_o = slot_q;
    emit_valid_o  = 1'b0;
    emit_beat_o   = '0;
    emit_beat_o.pending_count = PCNT_W'(fin_q);
    case (state_q)
      ST_POP: begin
        emit_valid_o               = rel && held_valid_q;
        emit_beat_o.release_valid  = 1'b1;
        emit_beat_o.release_slot   = held_slot_q;
      end
      ST_DONE: begin
        emit_valid_o                = 1'b1;
        emit_beat_o.release_valid   = held_valid_q;
        emit_beat_o.release_slot    = held_valid_q ? held_slot_q : '0;
        emit_beat_o.present_dropped = dropped_q;
        emit_beat_o.last            = 1'b1;
      end
      default: ;
    endcase
  end

  // Register updates
  always_comb begin
    count_d      = count_q;
    head_d       = head_q;
    lat_valid_d  = lat_valid_q;
    lat_slot_d   = lat_slot_q;
    held_valid_d = held_valid_q;
    held_slot_d  = held_slot_q;
    tgt_d        = tgt_q;
    fin_d        = fin_q;
    dropped_d    = dropped_q;
    append_d     = append_q;
    slot_d       = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          held_valid_d = 1'b0;
          dropped_d    = 1'b0;
          append_d     = 1'b0;
          slot_d       = in_slot_i[SLOT_W-1:0];
          tgt_d        = count_q;
          fin_d        = count_q;
          case (mode_e'(in_mode_i))
            MODE_PRESENT: begin
              if (in_slot_i >= slot_count_i) begin
                dropped_d = 1'b1;
              end else begin
                append_d = 1'b1;
                tgt_d    = drain_tgt;
                fin_d    = drain_tgt + CW'(1);
              end
            end
            MODE_SCANOUT: begin
              if (count_q != '0) begin
                tgt_d = count_dec;
                fin_d = count_dec;
              end
            end
            MODE_POOLRST: begin
              count_d     = '0;
              head_d      = '0;
              lat_valid_d = 1'b0;
              fin_d       = '0;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        if (pop_go) begin
          head_d      = head_inc;
          count_d     = count_dec;
          lat_slot_d  = mem_rd_data_i;
          lat_valid_d = 1'b1;
          // Replace the held release; the old one left as a non-final beat.
          if (rel) begin
            held_valid_d = 1'b1;
            held_slot_d  = lat_slot_q;
          end
        end
      end
      ST_DONE: begin
        if (done_go && append_q) begin
          count_d = count_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      lat_valid_q  <= 1'b0;
      lat_slot_q   <= '0;
      held_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      lat_valid_q  <= lat_valid_d;
      lat_slot_q   <= lat_slot_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_slot_q <= held_slot_d;
    tgt_q       <= tgt_d;
    fin_q       <= fin_d;
    dropped_q   <= dropped_d;
    append_q    <= append_d;
    slot_q      <= slot_d;
  end

  assign ring_count_o = count_q;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream-level test of display_buffer_release_tracker. Events go in on the
// slave side under random and steady pacing; a class-based checker predicts
// the slot release beats and compares every output beat field by field.
// ----------------------------------------------------------------------------
module tb
  import drt_pkg::*;
;

  localparam int unsigned RING_DEPTH  = 8;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC  = 12;
  localparam int unsigned PHASE_ITEMS = 60;

  // Tracks pending slots and the latched slot; holds the release beats owed.
  class release_checker;
    bit [1:0]    ring [RING_DEPTH];
    bit [2:0]    head;
    bit [3:0]    count;
    bit          latched_valid;
    bit [1:0]    latched_slot;
    int unsigned slot_count;
    bit [1:0]    released [$];
    beat_t       expected_beats [$];
    int          errors;

    function new();
      head          = '0;
      count         = '0;
      latched_valid = 1'b0;
      latched_slot  = '0;
      slot_count    = 3;
      errors        = 0;
    endfunction

    function void set_slot_count(logic [2:0] value);
      if (value < 1) slot_count = 1;
      else if (value > MAX_SLOTS) slot_count = MAX_SLOTS;
      else slot_count = 32'(value);
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction

    // Latch the head entry; hand back the old latched slot if it differs.
    function void pop_entry();
      bit [1:0] got;
      got   = ring[head];
      head  = head + 3'd1;
      count = count - 4'd1;
      if (latched_valid && latched_slot != got) released.push_back(latched_slot);
      latched_slot  = got;
      latched_valid = 1'b1;
    endfunction

    function void note_event(mode_e mode, logic [2:0] slot);
      bit          dropped;
      int unsigned thr;
      int          n;
      bit [2:0]    tail;
      beat_t       b;
      released.delete();
      dropped = 1'b0;
      case (mode)
        MODE_PRESENT: begin
          if (slot >= slot_count) begin
            dropped = 1'b1;
          end else begin
            thr = (slot_count > 2) ? slot_count - 1 : 2;
            while (count > 0 && (count >= thr || count >= RING_DEPTH - 1)) pop_entry();
            tail       = head + count[2:0];
            ring[tail] = slot[1:0];
            count      = count + 4'd1;
          end
        end
        MODE_SCANOUT: begin
          if (count > 0) pop_entry();
        end
        MODE_POOLRST: begin
          head          = '0;
          count         = '0;
          latched_valid = 1'b0;
        end
        default: ;
      endcase
      n = (released.size() > 0) ? released.size() : 1;
      for (int k = 0; k < n; k++) begin
        b.release_valid   = (released.size() > 0);
        b.release_slot    = (released.size() > 0) ? released[k] : 2'd0;
        b.present_dropped = (k == n - 1) && dropped;
        b.pending_count   = count;
        b.last            = (k == n - 1);
        expected_beats.push_back(b);
      end
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_beat(logic [7:0] data, logic tlast);
      beat_t e;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data 0x%02h last %0d",
                 $time, data, tlast);
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      compare_field("release_valid", int'(e.release_valid), int'(data[0]));
      compare_field("release_slot", int'(e.release_slot), int'(data[2:1]));
      compare_field("present_dropped", int'(e.present_dropped), int'(data[3]));
      compare_field("pending_count", int'(e.pending_count), int'(data[7:4]));
      compare_field("last", int'(e.last), int'(tlast));
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [2:0] cfg_wdata_i   = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [2:0] slot, [7:3] zero
  logic [1:0] s_axis_tuser  = '0;   // [1:0] mode
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [0] release_valid, [2:1] release_slot,
                                    // [3] present_dropped, [7:4] pending_count
  logic       m_axis_tlast;

  release_checker tracker;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 46;
  int unsigned stall_cycles  = 0;

  display_buffer_release_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sink pacing.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check output beats and count cycles without any beat moving.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_beat(m_axis_tdata, m_axis_tlast);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_event(mode_e mode, logic [2:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, slot};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_event(mode, slot);
    @(negedge clk_i);
  endtask

  // Hold the source until every owed beat is out, then let the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_slot_count(logic [2:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_slot_count(value);
  endtask

  // Mostly valid presents and scanouts; some bad slots, pool resets, unused.
  task automatic random_event();
    int          r;
    logic [2:0]  slot;
    r    = $urandom_range(99);
    slot = 3'($urandom_range(7));
    if (r < 50) send_event(MODE_PRESENT, 3'($urandom_range(tracker.slot_count - 1)));
    else if (r < 60) send_event(MODE_PRESENT, slot);
    else if (r < 88) send_event(MODE_SCANOUT, slot);
    else if (r < 94) send_event(MODE_POOLRST, slot);
    else send_event(MODE_UNUSED, slot);
  endtask

  initial begin
    logic [2:0] phase_cfg [8];
    phase_cfg = '{3'd2, 3'd7, 3'd1, 3'd3, 3'd4, 3'd0, 3'd6, 3'd5};
    tracker = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty scanout, unused mode, drain at threshold, bad slots,
    // relatching the same slot, pool reset.
    send_event(MODE_SCANOUT, 3'd0);
    send_event(MODE_UNUSED, 3'd7);
    send_event(MODE_PRESENT, 3'd0);
    send_event(MODE_PRESENT, 3'd1);
    send_event(MODE_PRESENT, 3'd2);
    send_event(MODE_SCANOUT, 3'd0);
    send_event(MODE_PRESENT, 3'd3);
    send_event(MODE_PRESENT, 3'd7);
    send_event(MODE_PRESENT, 3'd2);
    send_event(MODE_SCANOUT, 3'd5);
    send_event(MODE_SCANOUT, 3'd0);
    send_event(MODE_POOLRST, 3'd0);
    send_event(MODE_SCANOUT, 3'd0);
    drain_results();

    // Fill at four slots, then shrink to one so a present drains two entries.
    write_slot_count(3'd4);
    send_event(MODE_PRESENT, 3'd0);
    send_event(MODE_PRESENT, 3'd1);
    send_event(MODE_PRESENT, 3'd2);
    send_event(MODE_PRESENT, 3'd3);
    drain_results();
    write_slot_count(3'd0);
    send_event(MODE_PRESENT, 3'd0);
    send_event(MODE_PRESENT, 3'd1);
    send_event(MODE_SCANOUT, 3'd0);
    send_event(MODE_SCANOUT, 3'd0);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 30;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_slot_count(phase_cfg[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain_results();
        random_event();
      end
      drain_results();
    end

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/drt_pkg.sv
rtl/drt_ring.sv
rtl/drt_ctrl.sv
rtl/display_buffer_release_tracker.sv
test/tb.sv
